/* rtl/core/fes_pkg.sv */
package fes_pkg;

   localparam int WORDS_PER_LINE_DEF = 120;

   localparam int WORD_W     = 16;
   localparam int PIXEL_W    = 8;
   localparam int INDEX_W    = 15;
   localparam int ROWS_W     = 8;
   localparam int CSR_DATA_W = 32;
   localparam int LCG_W      = 32;

   localparam logic [ROWS_W-1:0]  ROWS_RESET = 8'd162;
   localparam logic [LCG_W-1:0]   SEED_RESET = 32'h5BD1_E995;
   localparam logic [LCG_W-1:0]   LCG_MUL    = 32'd1566083941;
   localparam logic [LCG_W-1:0]   LCG_ADD    = 32'd2531011;
   localparam logic [WORD_W-1:0]  SEED_OR    = 16'h1F1F;

   typedef enum logic [0:0] {
      CSR_FRAME_ROWS = 1'b0,
      CSR_SEED       = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [WORD_W-1:0] far;   // word line+1 back
      logic [WORD_W-1:0] mid;   // word one line back
      logic [WORD_W-1:0] near;  // word line-1 back
   } fes_taps_type;

   typedef struct packed {
      logic               is_seed;
      logic [INDEX_W-1:0] dst_index;
      logic [WORD_W-1:0]  rand_word;
   } fes_pos_type;

   // 255 * (four pixels) >> 10 for each half of the pair
   function automatic logic [WORD_W-1:0] smooth_pair(
      input logic [WORD_W-1:0] b,
      input logic [WORD_W-1:0] c,
      input logic [WORD_W-1:0] r,
      input logic [WORD_W-1:0] l
   );
      logic [9:0]  sum_e;
      logic [9:0]  sum_d;
      logic [17:0] prod_e;
      logic [17:0] prod_d;
      sum_e  = 10'(b[7:0]) + 10'(c[7:0]) + 10'(c[15:8]) + 10'(l[15:8]);
      sum_d  = 10'(b[15:8]) + 10'(c[15:8]) + 10'(r[7:0]) + 10'(b[7:0]);
      prod_e = {sum_e, 8'b0} - {8'b0, sum_e};
      prod_d = {sum_d, 8'b0} - {8'b0, sum_d};
      return {prod_d[17:10], prod_e[17:10]};
   endfunction

endpackage

/* rtl/core/fes_if.sv */
interface fes_req_if import fes_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] src_word;
   logic              frame_start;

   modport source (output valid, output src_word, output frame_start, input ready);
   modport sink   (input valid, input src_word, input frame_start, output ready);
endinterface

interface fes_rsp_if import fes_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [WORD_W-1:0]  dst_word;
   logic [INDEX_W-1:0] dst_index;
   logic               is_seed_row;

   modport source (output valid, output dst_word, output dst_index, output is_seed_row,
                   input ready);
   modport sink   (input valid, input dst_word, input dst_index, input is_seed_row,
                   output ready);
endinterface

interface fes_csr_if import fes_pkg::*; ();
   logic                  valid;
   logic                  ready;
   csr_index_type         index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/fes_ram.sv */
module fes_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 119
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/fes_delay_line.sv */
module fes_delay_line import fes_pkg::*; #(
   parameter int WORDS_PER_LINE = WORDS_PER_LINE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [WORD_W-1:0] wr_word,
   output fes_taps_type      taps
);

   localparam int DL_DEPTH = WORDS_PER_LINE - 1;
   localparam int AW       = $clog2(DL_DEPTH);
   localparam logic [AW-1:0] LAST = AW'(DL_DEPTH - 1);

   logic [AW-1:0]     wp_ff;
   logic [AW-1:0]     wp_in;
   logic [AW-1:0]     wp_inc;
   logic [WORD_W-1:0] near_word;
   logic [WORD_W-1:0] mid_ff;
   logic [WORD_W-1:0] far_ff;

   // the slot about to be overwritten holds the word line-1 back;
   // read ahead at the next pointer so data is ready for the next item
   assign wp_inc = (wp_ff == LAST) ? '0 : wp_ff + AW'(1);
   assign wp_in  = advance ? wp_inc : wp_ff;

   fes_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DL_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (wp_ff),
      .wr_data (wr_word),
      .rd_addr (wp_in),
      .rd_data (near_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
      end else begin
         wp_ff <= wp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mid_ff <= near_word;
         far_ff <= mid_ff;
      end
   end

   assign taps.near = near_word;
   assign taps.mid  = mid_ff;
   assign taps.far  = far_ff;

endmodule

/* rtl/core/fes_frame_ctrl.sv */
module fes_frame_ctrl import fes_pkg::*; #(
   parameter int WORDS_PER_LINE = WORDS_PER_LINE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  frame_start,
   input  logic                  csr_wr,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output fes_pos_type           pos_info
);

   localparam int POS_W = $clog2(((1 << ROWS_W) + 1) * WORDS_PER_LINE + 1);
   localparam int EXT_W = (POS_W + 1 > INDEX_W) ? POS_W + 1 : INDEX_W;
   localparam logic [POS_W-1:0] SEED_WORDS = POS_W'(2 * WORDS_PER_LINE);
   localparam logic [POS_W-1:0] LINE       = POS_W'(WORDS_PER_LINE);
   localparam logic [POS_W-1:0] BASE_RESET = POS_W'(int'(ROWS_RESET) * WORDS_PER_LINE);
   localparam logic [POS_W-1:0] LEN_RESET  =
      POS_W'((int'(ROWS_RESET) + 2) * WORDS_PER_LINE);

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic [POS_W-1:0] len_ff;
   logic [POS_W-1:0] base_ff;
   logic [LCG_W-1:0] lcg_ff;
   logic [POS_W-1:0] pos_cur;
   logic [POS_W-1:0] pos_nxt;
   logic [POS_W-1:0] rows_base;
   logic [LCG_W-1:0] lcg_next;
   logic [EXT_W-1:0] seed_idx;
   logic [EXT_W-1:0] smooth_idx;
   logic             is_seed;

   assign pos_cur  = (frame_start || pos_ff >= len_ff) ? '0 : pos_ff;
   assign pos_nxt  = pos_cur + POS_W'(1);
   assign pos_in   = (pos_nxt >= len_ff) ? '0 : pos_nxt;
   assign is_seed  = pos_cur < SEED_WORDS;

   assign lcg_next = lcg_ff * LCG_MUL + LCG_ADD;

   assign seed_idx   = EXT_W'(base_ff) + EXT_W'(pos_cur);
   assign smooth_idx = EXT_W'(pos_cur) - EXT_W'(SEED_WORDS);

   assign rows_base = POS_W'(csr_data[ROWS_W-1:0]) * LINE;

   assign pos_info.is_seed   = is_seed;
   assign pos_info.dst_index = is_seed ? seed_idx[INDEX_W-1:0] : smooth_idx[INDEX_W-1:0];
   assign pos_info.rand_word = lcg_next[LCG_W-1:LCG_W-WORD_W] | SEED_OR;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         len_ff  <= LEN_RESET;
         base_ff <= BASE_RESET;
         lcg_ff  <= SEED_RESET;
      end else begin
         if (advance) begin
            pos_ff <= pos_in;
            if (is_seed) begin
               lcg_ff <= lcg_next;
            end
         end
         if (csr_wr) begin
            case (csr_index)
               CSR_FRAME_ROWS: begin
                  base_ff <= rows_base;
                  len_ff  <= rows_base + SEED_WORDS;
               end
               CSR_SEED: begin
                  lcg_ff <= csr_data[LCG_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

/* rtl/core/fire_effect_stencil_unit.sv */
// Fire effect stencil. Takes the previous fire frame as a stream of 16-bit words
// (two 8-bit pixels, low byte even) and returns one word of the new frame per
// item with its destination word index. The first two source lines of a frame
// produce LCG random seed words ORed with 0x1F1F (is_seed_row set); every later
// word yields a smoothed pixel pair from four neighbors, three from a one-line
// delay line. A word with frame_start high restarts the position at zero, as
// does the end of a frame of frame_rows + 2 lines. Rate is one item per clock
// while the output is not stalled: the smoothing and the LCG step sit between
// the input handshake and a single output register, and the delay line is a RAM
// with one write and one read per cycle plus two tap registers. Configuration
// writes take effect immediately and should only be issued while the unit is
// idle; writing the seed reloads the generator state.
module fire_effect_stencil_unit import fes_pkg::*; #(
   parameter int WORDS_PER_LINE = WORDS_PER_LINE_DEF
) (
   input  logic  clock,
   input  logic  reset,
   fes_req_if.sink   req_ch,
   fes_rsp_if.source rsp_ch,
   fes_csr_if.sink   csr_ch
);

   logic               accept;
   logic               csr_wr;
   fes_taps_type       taps;
   fes_pos_type        pos_info;
   logic               rsp_valid_ff;
   logic [WORD_W-1:0]  dst_word_ff;
   logic [WORD_W-1:0]  dst_word_in;
   logic [INDEX_W-1:0] dst_index_ff;
   logic               is_seed_ff;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign csr_wr       = csr_ch.valid;

   fes_delay_line #(
      .WORDS_PER_LINE (WORDS_PER_LINE)
   ) u_delay_line (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .wr_word (req_ch.src_word),
      .taps    (taps)
   );

   fes_frame_ctrl #(
      .WORDS_PER_LINE (WORDS_PER_LINE)
   ) u_frame_ctrl (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept),
      .frame_start (req_ch.frame_start),
      .csr_wr      (csr_wr),
      .csr_index   (csr_ch.index),
      .csr_data    (csr_ch.data),
      .pos_info    (pos_info)
   );

   assign dst_word_in = pos_info.is_seed ? pos_info.rand_word
                      : smooth_pair(taps.mid, req_ch.src_word, taps.near, taps.far);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dst_word_ff  <= dst_word_in;
         dst_index_ff <= pos_info.dst_index;
         is_seed_ff   <= pos_info.is_seed;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.dst_word    = dst_word_ff;
   assign rsp_ch.dst_index   = dst_index_ff;
   assign rsp_ch.is_seed_row = is_seed_ff;

endmodule
